[rtl/fpa_pkg.sv]
`timescale 1ns / 1ps

package fpa_pkg;

	typedef enum logic [3:0] {
		FUNC_ADD = 4'd0,
		FUNC_SUB = 4'd1,
		FUNC_MUL = 4'd2,
		FUNC_DIV = 4'd3,
		FUNC_GT  = 4'd4,
		FUNC_LT  = 4'd5,
		FUNC_GE  = 4'd6,
		FUNC_LE  = 4'd7,
		FUNC_EQ  = 4'd8,
		FUNC_NE  = 4'd9,
		FUNC_MIN = 4'd10,
		FUNC_MAX = 4'd11
	} func_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OVF  = 2'd1,
		ST_DIVZ = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		KIND_PRESET = 2'd0,
		KIND_MUL    = 2'd1,
		KIND_DIV    = 2'd2
	} kind_t;

	typedef struct packed {
		logic    valid;
		kind_t   kind;
		logic    neg;
		logic    cmp;
		status_t status;
	} ctrl_t;

endpackage

[rtl/fpa_cmd_if.sv]
`timescale 1ns / 1ps

interface fpa_cmd_if #(parameter int WORD_BITS = 32);
	import fpa_pkg::*;

	logic                        valid;
	logic                        ready;
	func_t                       func;
	logic signed [WORD_BITS-1:0] operand_a;
	logic signed [WORD_BITS-1:0] operand_b;

	modport source(output valid, func, operand_a, operand_b, input ready);
	modport sink(input valid, func, operand_a, operand_b, output ready);
endinterface

[rtl/fpa_res_if.sv]
`timescale 1ns / 1ps

interface fpa_res_if #(parameter int WORD_BITS = 32);
	import fpa_pkg::*;

	logic                        valid;
	logic                        ready;
	logic signed [WORD_BITS-1:0] result_value;
	logic                        compare_true;
	status_t                     status;

	modport source(output valid, result_value, compare_true, status, input ready);
	modport sink(input valid, result_value, compare_true, status, output ready);
endinterface

[rtl/fixed_point_q24_8_alu_top.sv]
`timescale 1ns / 1ps
// Channel  Role    Fields
// cmd      sink    func, operand_a, operand_b
// res      source  result_value, compare_true, status
//
// One beat is taken in every cycle while the skid register is empty; each result
// passes through the row of one cell per quotient bit that lies behind the operand
// stage and ahead of the output register.
// Reset clears all valid flags at once; there is no clearing pass.
// A stalled result is held in the output register and a skid register, and
// the whole row of cells holds while the skid register is full.

module fixed_point_q24_8_alu_top #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 8
) (
	input logic clk,
	input logic arst_n,
	fpa_cmd_if.sink   cmd,
	fpa_res_if.source res
);
	import fpa_pkg::*;

	localparam int W  = WORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int NB = W + F;

	logic en;

	ctrl_t          ctrl_c   [0:NB];
	logic [W-1:0]   preset_c [0:NB];
	logic [2*W-1:0] acc_c    [0:NB];
	logic [W-1:0]   mcand_c  [0:NB];
	logic [W-1:0]   mplier_c [0:NB];
	logic [W-1:0]   rem_c    [0:NB];
	logic [NB-1:0]  num_c    [0:NB];
	logic [NB-1:0]  quo_c    [0:NB];
	logic [W-1:0]   dvs_c    [0:NB];

	logic [W-1:0] fin_value;
	logic         fin_cmp;
	status_t      fin_status;

	logic         out_vld_q;
	logic [W-1:0] out_value_q;
	logic         out_cmp_q;
	status_t      out_status_q;
	logic         skid_vld_q;
	logic [W-1:0] skid_value_q;
	logic         skid_cmp_q;
	status_t      skid_status_q;
	logic         take;
	logic         load_out;

	assign en        = !skid_vld_q;
	assign cmd.ready = en;

	fpa_prep #(.W(W), .F(F)) u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld     (cmd.valid),
		.func    (cmd.func),
		.a       (cmd.operand_a),
		.b       (cmd.operand_b),
		.ctrl_o  (ctrl_c[0]),
		.preset_o(preset_c[0]),
		.acc_o   (acc_c[0]),
		.mcand_o (mcand_c[0]),
		.mplier_o(mplier_c[0]),
		.rem_o   (rem_c[0]),
		.num_o   (num_c[0]),
		.quo_o   (quo_c[0]),
		.dvs_o   (dvs_c[0])
	);

	for (genvar i = 0; i < NB; i++) begin : g_cell
		fpa_cell #(.W(W), .F(F), .IDX(i)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.ctrl_i  (ctrl_c[i]),
			.preset_i(preset_c[i]),
			.acc_i   (acc_c[i]),
			.mcand_i (mcand_c[i]),
			.mplier_i(mplier_c[i]),
			.rem_i   (rem_c[i]),
			.num_i   (num_c[i]),
			.quo_i   (quo_c[i]),
			.dvs_i   (dvs_c[i]),
			.ctrl_o  (ctrl_c[i+1]),
			.preset_o(preset_c[i+1]),
			.acc_o   (acc_c[i+1]),
			.mcand_o (mcand_c[i+1]),
			.mplier_o(mplier_c[i+1]),
			.rem_o   (rem_c[i+1]),
			.num_o   (num_c[i+1]),
			.quo_o   (quo_c[i+1]),
			.dvs_o   (dvs_c[i+1])
		);
	end

	fpa_finish #(.W(W), .F(F)) u_finish (
		.ctrl_i  (ctrl_c[NB]),
		.preset_i(preset_c[NB]),
		.acc_i   (acc_c[NB]),
		.rem_i   (rem_c[NB]),
		.quo_i   (quo_c[NB]),
		.dvs_i   (dvs_c[NB]),
		.value   (fin_value),
		.cmp     (fin_cmp),
		.status  (fin_status)
	);

	assign take     = out_vld_q && res.ready;
	assign load_out = !out_vld_q || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (load_out) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= ctrl_c[NB].valid;
			end
		end else if (en && ctrl_c[NB].valid) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (skid_vld_q) begin
				out_value_q  <= skid_value_q;
				out_cmp_q    <= skid_cmp_q;
				out_status_q <= skid_status_q;
			end else begin
				out_value_q  <= fin_value;
				out_cmp_q    <= fin_cmp;
				out_status_q <= fin_status;
			end
		end else if (en && ctrl_c[NB].valid) begin
			skid_value_q  <= fin_value;
			skid_cmp_q    <= fin_cmp;
			skid_status_q <= fin_status;
		end
	end

	assign res.valid        = out_vld_q;
	assign res.result_value = out_value_q;
	assign res.compare_true = out_cmp_q;
	assign res.status       = out_status_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("Skid register holds a beat while the output register is empty.");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && !res.ready))
		else $error("Skid register filled while the output register could move.");

	a_cmp_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_cmp_q) |-> (out_value_q == '0 && out_status_q == ST_OK))
		else $error("A comparison result carries a nonzero value or status.");

	a_divz_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_status_q == ST_DIVZ) |->
		(out_value_q == {1'b1, {(W-1){1'b0}}} || out_value_q == {1'b0, {(W-1){1'b1}}}))
		else $error("Division by zero did not give a saturated value.");
endmodule

[rtl/fpa_prep.sv]
`timescale 1ns / 1ps

module fpa_prep #(
	parameter int W = 32,
	parameter int F = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld,
	input  fpa_pkg::func_t      func,
	input  logic signed [W-1:0] a,
	input  logic signed [W-1:0] b,
	output fpa_pkg::ctrl_t      ctrl_o,
	output logic [W-1:0]        preset_o,
	output logic [2*W-1:0]      acc_o,
	output logic [W-1:0]        mcand_o,
	output logic [W-1:0]        mplier_o,
	output logic [W-1:0]        rem_o,
	output logic [W+F-1:0]      num_o,
	output logic [W+F-1:0]      quo_o,
	output logic [W-1:0]        dvs_o
);
	import fpa_pkg::*;

	localparam int NB = W + F;

	logic [W:0]   sum;
	logic [W:0]   dif;
	logic [W-1:0] max_w;
	logic [W-1:0] min_w;
	logic [W-1:0] mag_a;
	logic [W-1:0] mag_b;
	ctrl_t        ctrl_d;
	logic [W-1:0] preset_d;

	assign max_w = {1'b0, {(W-1){1'b1}}};
	assign min_w = {1'b1, {(W-1){1'b0}}};
	assign sum   = {a[W-1], a} + {b[W-1], b};
	assign dif   = {a[W-1], a} - {b[W-1], b};
	assign mag_a = a[W-1] ? W'(-a) : W'(a);
	assign mag_b = b[W-1] ? W'(-b) : W'(b);

	always_comb begin
		ctrl_d        = '0;
		ctrl_d.valid  = vld;
		ctrl_d.kind   = KIND_PRESET;
		ctrl_d.status = ST_OK;
		ctrl_d.neg    = a[W-1] ^ b[W-1];
		preset_d      = '0;
		case (func)
			FUNC_ADD: begin
				if (sum[W] != sum[W-1]) begin
					preset_d      = sum[W] ? min_w : max_w;
					ctrl_d.status = ST_OVF;
				end else begin
					preset_d = sum[W-1:0];
				end
			end
			FUNC_SUB: begin
				if (dif[W] != dif[W-1]) begin
					preset_d      = dif[W] ? min_w : max_w;
					ctrl_d.status = ST_OVF;
				end else begin
					preset_d = dif[W-1:0];
				end
			end
			FUNC_MUL: ctrl_d.kind = KIND_MUL;
			FUNC_DIV: begin
				if (b == '0) begin
					preset_d      = a[W-1] ? min_w : max_w;
					ctrl_d.status = ST_DIVZ;
				end else begin
					ctrl_d.kind = KIND_DIV;
				end
			end
			FUNC_GT:  ctrl_d.cmp = a > b;
			FUNC_LT:  ctrl_d.cmp = a < b;
			FUNC_GE:  ctrl_d.cmp = a >= b;
			FUNC_LE:  ctrl_d.cmp = a <= b;
			FUNC_EQ:  ctrl_d.cmp = a == b;
			FUNC_NE:  ctrl_d.cmp = a != b;
			FUNC_MIN: preset_d = (b < a) ? b : a;
			FUNC_MAX: preset_d = (a < b) ? b : a;
			default: begin
				preset_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_o <= '0;
		end else if (en) begin
			ctrl_o <= ctrl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			preset_o <= preset_d;
			acc_o    <= '0;
			mcand_o  <= mag_a;
			mplier_o <= mag_b;
			rem_o    <= '0;
			num_o    <= NB'(mag_a) << F;
			quo_o    <= '0;
			dvs_o    <= mag_b;
		end
	end
endmodule

[rtl/fpa_cell.sv]
`timescale 1ns / 1ps

module fpa_cell #(
	parameter int W   = 32,
	parameter int F   = 8,
	parameter int IDX = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  fpa_pkg::ctrl_t ctrl_i,
	input  logic [W-1:0]   preset_i,
	input  logic [2*W-1:0] acc_i,
	input  logic [W-1:0]   mcand_i,
	input  logic [W-1:0]   mplier_i,
	input  logic [W-1:0]   rem_i,
	input  logic [W+F-1:0] num_i,
	input  logic [W+F-1:0] quo_i,
	input  logic [W-1:0]   dvs_i,
	output fpa_pkg::ctrl_t ctrl_o,
	output logic [W-1:0]   preset_o,
	output logic [2*W-1:0] acc_o,
	output logic [W-1:0]   mcand_o,
	output logic [W-1:0]   mplier_o,
	output logic [W-1:0]   rem_o,
	output logic [W+F-1:0] num_o,
	output logic [W+F-1:0] quo_o,
	output logic [W-1:0]   dvs_o
);
	import fpa_pkg::*;

	localparam int NB = W + F;

	// Each cell adds one partial product and develops one quotient bit.
	logic [2*W-1:0] addend;
	logic [W:0]     trial;
	logic [W:0]     diff;
	logic           fits;

	assign addend = mplier_i[0] ? ((2*W)'(mcand_i) << IDX) : '0;
	assign trial  = {rem_i, num_i[NB-1]};
	assign diff   = trial - {1'b0, dvs_i};
	assign fits   = trial >= {1'b0, dvs_i};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_o <= '0;
		end else if (en) begin
			ctrl_o <= ctrl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			preset_o <= preset_i;
			acc_o    <= acc_i + addend;
			mcand_o  <= mcand_i;
			mplier_o <= mplier_i >> 1;
			rem_o    <= fits ? diff[W-1:0] : trial[W-1:0];
			num_o    <= num_i << 1;
			quo_o    <= {quo_i[NB-2:0], fits};
			dvs_o    <= dvs_i;
		end
	end
endmodule

[rtl/fpa_finish.sv]
`timescale 1ns / 1ps

module fpa_finish #(
	parameter int W = 32,
	parameter int F = 8
) (
	input  fpa_pkg::ctrl_t   ctrl_i,
	input  logic [W-1:0]     preset_i,
	input  logic [2*W-1:0]   acc_i,
	input  logic [W-1:0]     rem_i,
	input  logic [W+F-1:0]   quo_i,
	input  logic [W-1:0]     dvs_i,
	output logic [W-1:0]     value,
	output logic             cmp,
	output fpa_pkg::status_t status
);
	import fpa_pkg::*;

	localparam int MW = 2 * W + F + 2;
	localparam logic [2*W:0] RND = ((2*W+1)'(1) << F) >> 1;
	localparam logic [MW-1:0] HALF = MW'(1) << (W - 1);

	logic [2*W:0]  prod_r;
	logic          rnd_up;
	logic [MW-1:0] mag;
	logic [MW-1:0] lim;
	logic [W-1:0]  low;

	assign prod_r = {1'b0, acc_i} + RND;
	assign rnd_up = {rem_i, 1'b0} >= {1'b0, dvs_i};
	assign mag = (ctrl_i.kind == KIND_MUL) ? MW'(prod_r >> F)
		: (MW'(quo_i) + MW'(rnd_up));
	assign lim = ctrl_i.neg ? HALF : HALF - MW'(1);
	assign low = mag[W-1:0];

	always_comb begin
		value  = preset_i;
		cmp    = ctrl_i.cmp;
		status = ctrl_i.status;
		if (ctrl_i.kind == KIND_MUL || ctrl_i.kind == KIND_DIV) begin
			if (mag > lim) begin
				status = ST_OVF;
				value  = ctrl_i.neg ? HALF[W-1:0] : HALF[W-1:0] - W'(1);
			end else begin
				status = ST_OK;
				value  = ctrl_i.neg ? W'(-low) : low;
			end
		end
	end
endmodule
